@@ rtl/core/hrkem_pkg.sv @@
package hrkem_pkg;

  // number of report slots carried on the input ports
  localparam int NUM_IN_FIELDS = 6;

  // widths of the event fields
  localparam int CODE_W = 8;
  localparam int BTN_W  = 4;
  localparam int MASK_W = 14;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [BTN_W-1:0]  button_t;
  typedef logic [MASK_W-1:0] mask_t;

  // usage codes
  localparam code_t KEY_NONE   = 8'h00;
  localparam code_t KEY_UP     = 8'h52;
  localparam code_t KEY_DOWN   = 8'h51;
  localparam code_t KEY_LEFT   = 8'h50;
  localparam code_t KEY_RIGHT  = 8'h4F;
  localparam code_t KEY_A      = 8'h04;
  localparam code_t KEY_S      = 8'h16;
  localparam code_t KEY_D      = 8'h07;
  localparam code_t KEY_ENTER  = 8'h28;
  localparam code_t KEY_KPENT  = 8'h58;
  localparam code_t KEY_Q      = 8'h14;
  localparam code_t KEY_W      = 8'h1A;
  localparam code_t KEY_E      = 8'h08;
  localparam code_t KEY_LALT   = 8'hE2;
  localparam code_t KEY_RALT   = 8'hE6;
  localparam code_t KEY_SPACE  = 8'h2C;
  localparam code_t KEY_ESC    = 8'h29;

  // button codes
  localparam button_t BTN_NONE   = 4'd0;
  localparam button_t BTN_UP     = 4'd1;
  localparam button_t BTN_DOWN   = 4'd2;
  localparam button_t BTN_LEFT   = 4'd3;
  localparam button_t BTN_RIGHT  = 4'd4;
  localparam button_t BTN_A      = 4'd5;
  localparam button_t BTN_B      = 4'd6;
  localparam button_t BTN_C      = 4'd7;
  localparam button_t BTN_START  = 4'd8;
  localparam button_t BTN_X      = 4'd9;
  localparam button_t BTN_Y      = 4'd10;
  localparam button_t BTN_Z      = 4'd11;
  localparam button_t BTN_MODE   = 4'd12;
  localparam button_t BTN_SELECT = 4'd13;
  localparam button_t BTN_ESCAPE = 4'd14;

  // usage code to button, BTN_NONE when unmapped
  function automatic button_t map_button(input code_t code);
    button_t b;
    case (code)
      KEY_UP:    b = BTN_UP;
      KEY_DOWN:  b = BTN_DOWN;
      KEY_LEFT:  b = BTN_LEFT;
      KEY_RIGHT: b = BTN_RIGHT;
      KEY_A:     b = BTN_A;
      KEY_S:     b = BTN_B;
      KEY_D:     b = BTN_C;
      KEY_ENTER: b = BTN_START;
      KEY_KPENT: b = BTN_START;
      KEY_Q:     b = BTN_X;
      KEY_W:     b = BTN_Y;
      KEY_E:     b = BTN_Z;
      KEY_LALT:  b = BTN_MODE;
      KEY_RALT:  b = BTN_MODE;
      KEY_SPACE: b = BTN_SELECT;
      KEY_ESC:   b = BTN_ESCAPE;
      default:   b = BTN_NONE;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/hid_report_key_event_mapper.sv @@
// path: the first event of a report passes the queue, the record register and the output
//   register when the back end is idle, later while earlier events are still draining
// throughput: one event per cycle while out_ready is high; a report with k mapped changes
//   gives k events, at most 2*REPORT_SLOTS
// a report with no mapped change is absorbed at intake and gives no result
// reset: synchronous, clears previous report, held mask, queue and output valid
module hid_report_key_event_mapper #(
  parameter int REPORT_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hrkem_pkg::code_t     key_slot_0,
  input  hrkem_pkg::code_t     key_slot_1,
  input  hrkem_pkg::code_t     key_slot_2,
  input  hrkem_pkg::code_t     key_slot_3,
  input  hrkem_pkg::code_t     key_slot_4,
  input  hrkem_pkg::code_t     key_slot_5,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_press,
  output hrkem_pkg::button_t   button,
  output hrkem_pkg::mask_t     held_mask,
  output logic                 last_event
);
  import hrkem_pkg::*;

  localparam int NEV   = 2 * REPORT_SLOTS;
  localparam int REC_W = NEV * (BTN_W + 1);

  logic                 push;
  logic                 push_ready;
  logic [NEV-1:0]       ev_vld;
  button_t [NEV-1:0]    ev_btn;
  logic                 q_valid;
  logic                 q_ready;
  logic [REC_W-1:0]     q_data;
  logic [NEV-1:0]       q_vld;
  button_t [NEV-1:0]    q_btn;

  // report intake and change classification
  hrkem_front #(.SLOTS(REPORT_SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_slot_0 (key_slot_0),
    .key_slot_1 (key_slot_1),
    .key_slot_2 (key_slot_2),
    .key_slot_3 (key_slot_3),
    .key_slot_4 (key_slot_4),
    .key_slot_5 (key_slot_5),
    .push       (push),
    .ev_vld     (ev_vld),
    .ev_btn     (ev_btn),
    .q_ready    (push_ready)
  );

  // event records between front and back
  hrkem_queue #(.WIDTH(REC_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  ({ev_btn, ev_vld}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_vld = q_data[NEV-1:0];
  assign q_btn = q_data[REC_W-1:NEV];

  // event emission and held mask
  hrkem_back #(.SLOTS(REPORT_SLOTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_vld      (q_vld),
    .q_btn      (q_btn),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_press   (is_press),
    .button     (button),
    .held_mask  (held_mask),
    .last_event (last_event)
  );

endmodule

@@ rtl/core/hrkem_front.sv @@
module hrkem_front #(
  parameter int SLOTS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hrkem_pkg::code_t           key_slot_0,
  input  hrkem_pkg::code_t           key_slot_1,
  input  hrkem_pkg::code_t           key_slot_2,
  input  hrkem_pkg::code_t           key_slot_3,
  input  hrkem_pkg::code_t           key_slot_4,
  input  hrkem_pkg::code_t           key_slot_5,
  output logic                       push,
  output logic [2*SLOTS-1:0]         ev_vld,
  output hrkem_pkg::button_t [2*SLOTS-1:0] ev_btn,
  input  logic                       q_ready
);
  import hrkem_pkg::*;

  code_t             fields [NUM_IN_FIELDS];
  code_t             cur    [SLOTS];
  code_t             prev   [SLOTS];
  logic [SLOTS-1:0]  hit_new;
  logic [SLOTS-1:0]  hit_old;
  logic              accept;

  assign fields[0] = key_slot_0;
  assign fields[1] = key_slot_1;
  assign fields[2] = key_slot_2;
  assign fields[3] = key_slot_3;
  assign fields[4] = key_slot_4;
  assign fields[5] = key_slot_5;

  // slots past the input ports read as empty
  for (genvar i = 0; i < SLOTS; i++) begin : g_cur
    if (i < NUM_IN_FIELDS) begin : g_port
      assign cur[i] = fields[i];
    end else begin : g_empty
      assign cur[i] = KEY_NONE;
    end
  end

  // cross compare new and previous report
  always_comb begin
    hit_new = '0;
    hit_old = '0;
    for (int i = 0; i < SLOTS; i++) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (prev[j] == cur[i]) hit_new[i] = 1'b1;
        if (cur[j] == prev[i]) hit_old[i] = 1'b1;
      end
    end
  end

  // classify: presses in the low half, releases in the high half
  for (genvar i = 0; i < SLOTS; i++) begin : g_class
    assign ev_btn[i]         = map_button(cur[i]);
    assign ev_btn[SLOTS + i] = map_button(prev[i]);
    assign ev_vld[i] = (cur[i] != KEY_NONE) && !hit_new[i] && (ev_btn[i] != BTN_NONE);
    assign ev_vld[SLOTS + i] = (prev[i] != KEY_NONE) && !hit_old[i] &&
                               (ev_btn[SLOTS + i] != BTN_NONE);
  end

  // handshake: a report with no mapped change is dropped here
  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign push     = accept && (|ev_vld);

  // previous report
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) prev[i] <= KEY_NONE;
    end else if (accept) begin
      for (int i = 0; i < SLOTS; i++) prev[i] <= cur[i];
    end
  end

endmodule

@@ rtl/core/hrkem_queue.sv @@
module hrkem_queue #(
  parameter int WIDTH = 60
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // two-entry storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/hrkem_back.sv @@
module hrkem_back #(
  parameter int SLOTS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [2*SLOTS-1:0]         q_vld,
  input  hrkem_pkg::button_t [2*SLOTS-1:0] q_btn,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_press,
  output hrkem_pkg::button_t         button,
  output hrkem_pkg::mask_t           held_mask,
  output logic                       last_event
);
  import hrkem_pkg::*;

  localparam int NEV = 2 * SLOTS;

  logic [NEV-1:0]          vld;
  logic [NEV-1:0]          vld_next;
  button_t [NEV-1:0]       btn;
  logic [NEV-1:0]          pick;
  logic [NEV-1:0]          rest;
  button_t                 sel_btn;
  mask_t                   btn_bit;
  mask_t                   held_next;
  logic                    busy;
  logic                    out_free;
  logic                    emit;
  logic                    pop;

  assign busy     = |vld;
  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;

  // lowest pending event
  assign pick = vld & (~vld + NEV'(1));
  assign rest = vld & ~pick;

  always_comb begin
    sel_btn = BTN_NONE;
    for (int i = 0; i < NEV; i++) begin
      if (pick[i]) sel_btn = sel_btn | btn[i];
    end
  end

  // mask bit for the selected button
  always_comb begin
    for (int k = 0; k < MASK_W; k++) btn_bit[k] = (sel_btn == BTN_W'(k + 1));
  end

  assign held_next = (|pick[SLOTS-1:0]) ? (held_mask | btn_bit) : (held_mask & ~btn_bit);

  // load the next record as the current one runs out
  assign pop      = q_valid && (!busy || (emit && (rest == '0)));
  assign q_ready  = pop;
  assign vld_next = pop ? q_vld : (emit ? rest : vld);

  // record being worked
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) btn <= q_btn;
  end

  // output register and held mask
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_mask <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        held_mask <= held_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_press   <= |pick[SLOTS-1:0];
      button     <= sel_btn;
      last_event <= (rest == '0);
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrkem_pkg::*;

  localparam int SLOTS         = 6;
  localparam int RANDOM_COUNT  = 266;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLDOFF_LEN   = 300;
  localparam int HOLDOFF_AT    = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    code_t keys [SLOTS];
  } report_t;

  typedef struct packed {
    logic    is_press;
    button_t button;
    mask_t   mask;
    logic    last;
  } key_event_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  code_t   key_slot_0 = KEY_NONE;
  code_t   key_slot_1 = KEY_NONE;
  code_t   key_slot_2 = KEY_NONE;
  code_t   key_slot_3 = KEY_NONE;
  code_t   key_slot_4 = KEY_NONE;
  code_t   key_slot_5 = KEY_NONE;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    is_press;
  button_t button;
  mask_t   held_mask;
  logic    last_event;

  hid_report_key_event_mapper DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_slot_0 (key_slot_0),
    .key_slot_1 (key_slot_1),
    .key_slot_2 (key_slot_2),
    .key_slot_3 (key_slot_3),
    .key_slot_4 (key_slot_4),
    .key_slot_5 (key_slot_5),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_press   (is_press),
    .button     (button),
    .held_mask  (held_mask),
    .last_event (last_event)
  );

  always #6 clk = ~clk;

  // stimulus and scoreboard state
  report_t    report_queue [$];
  key_event_t expected_events [$];
  button_t    key_button [256];
  code_t      mapped_keys [16];
  report_t    last_keys;
  mask_t      held_now;
  report_t    next_report;

  int total_reports = 1;
  int reports_sent = 0;
  int reports_accepted = 0;
  int mismatch_count = 0;
  int events_checked = 0;
  int press_count = 0;
  int release_count = 0;
  int silent_reports = 0;
  int full_reports = 0;
  int input_stall_cycles = 0;
  int quiet_cycles = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  // idle percentage for the current third of the run
  function automatic int idle_pct(input bit for_sender);
    int ph;
    ph = (reports_sent * 3) / total_reports;
    if (ph == 0) return for_sender ? 10 : 68;
    if (ph == 1) return for_sender ? 68 : 10;
    return 0;
  endfunction

  function automatic bit report_has(input report_t r, input code_t c);
    for (int j = 0; j < SLOTS; j++)
      if (r.keys[j] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic report_t make_report(input code_t k0, input code_t k1, input code_t k2,
                                          input code_t k3, input code_t k4, input code_t k5);
    report_t r;
    r.keys = '{k0, k1, k2, k3, k4, k5};
    return r;
  endfunction

  // mostly mapped keys, some empty slots, some arbitrary codes
  function automatic code_t pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return mapped_keys[$urandom_range(0, 15)];
    if (roll < 80) return KEY_NONE;
    return code_t'($urandom_range(0, 255));
  endfunction

  // diff a request against the held report and queue the events it causes
  task automatic diff_report(input report_t r);
    key_event_t evs [$];
    key_event_t ev;
    button_t    b;
    for (int i = 0; i < SLOTS; i++) begin
      b = key_button[r.keys[i]];
      if (r.keys[i] != KEY_NONE && !report_has(last_keys, r.keys[i]) && b != BTN_NONE) begin
        held_now = held_now | (mask_t'(1) << (b - 1));
        ev = '{is_press: 1'b1, button: b, mask: held_now, last: 1'b0};
        evs.push_back(ev);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      b = key_button[last_keys.keys[i]];
      if (last_keys.keys[i] != KEY_NONE && !report_has(r, last_keys.keys[i]) &&
          b != BTN_NONE) begin
        held_now = held_now & ~(mask_t'(1) << (b - 1));
        ev = '{is_press: 1'b0, button: b, mask: held_now, last: 1'b0};
        evs.push_back(ev);
      end
    end
    if (evs.size() == 0) silent_reports++;
    if (evs.size() == 2 * SLOTS) full_reports++;
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[k]) expected_events.push_back(evs[k]);
    last_keys = r;
  endtask

  // driver: offer requests from the queue, hold until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || reports_accepted == reports_sent) begin
        if (report_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          next_report = report_queue.pop_front();
          key_slot_0 <= next_report.keys[0];
          key_slot_1 <= next_report.keys[1];
          key_slot_2 <= next_report.keys[2];
          key_slot_3 <= next_report.keys[3];
          key_slot_4 <= next_report.keys[4];
          key_slot_5 <= next_report.keys[5];
          in_valid <= 1'b1;
          reports_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure plus one long hold-off early on
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (!holdoff_done && reports_sent >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // monitor: predict on accepted requests, check accepted events, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_ready) input_stall_cycles++;
      if (in_valid && in_ready) begin
        diff_report(make_report(key_slot_0, key_slot_1, key_slot_2,
                                key_slot_3, key_slot_4, key_slot_5));
        reports_accepted++;
      end
      if (out_valid && out_ready) begin
        events_checked++;
        if (is_press) press_count++;
        else release_count++;
        if (expected_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] unexpected event: press=%0b button=%0d mask=%04h last=%0b",
                     $realtime, is_press, button, held_mask, last_event);
        end else begin
          key_event_t exp_ev;
          exp_ev = expected_events.pop_front();
          if (is_press !== exp_ev.is_press || button !== exp_ev.button ||
              held_mask !== exp_ev.mask || last_event !== exp_ev.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"[%0t] event mismatch: exp press=%0b button=%0d mask=%04h last=%0b,",
                        " got press=%0b button=%0d mask=%04h last=%0b"},
                       $realtime, exp_ev.is_press, exp_ev.button, exp_ev.mask, exp_ev.last,
                       is_press, button, held_mask, last_event);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d events outstanding",
                 QUIET_LIMIT, expected_events.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    report_t r;
    report_t prev_r;
    int      mode;
    int      idx;

    // usage code to button table
    for (int i = 0; i < 256; i++) key_button[i] = BTN_NONE;
    key_button[KEY_UP]    = BTN_UP;
    key_button[KEY_DOWN]  = BTN_DOWN;
    key_button[KEY_LEFT]  = BTN_LEFT;
    key_button[KEY_RIGHT] = BTN_RIGHT;
    key_button[KEY_A]     = BTN_A;
    key_button[KEY_S]     = BTN_B;
    key_button[KEY_D]     = BTN_C;
    key_button[KEY_ENTER] = BTN_START;
    key_button[KEY_KPENT] = BTN_START;
    key_button[KEY_Q]     = BTN_X;
    key_button[KEY_W]     = BTN_Y;
    key_button[KEY_E]     = BTN_Z;
    key_button[KEY_LALT]  = BTN_MODE;
    key_button[KEY_RALT]  = BTN_MODE;
    key_button[KEY_SPACE] = BTN_SELECT;
    key_button[KEY_ESC]   = BTN_ESCAPE;
    mapped_keys = '{KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_A, KEY_S, KEY_D, KEY_ENTER,
                    KEY_KPENT, KEY_Q, KEY_W, KEY_E, KEY_LALT, KEY_RALT, KEY_SPACE, KEY_ESC};
    for (int i = 0; i < SLOTS; i++) last_keys.keys[i] = KEY_NONE;
    held_now = '0;

    // directed requests
    // empty report, nothing changes
    report_queue.push_back(make_report(KEY_NONE, KEY_NONE, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    report_queue.push_back(make_report(KEY_UP, KEY_NONE, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    report_queue.push_back(make_report(KEY_UP, KEY_DOWN, KEY_LEFT,
                                       KEY_RIGHT, KEY_A, KEY_S));
    // same keys in other slots, no events
    report_queue.push_back(make_report(KEY_S, KEY_RIGHT, KEY_A,
                                       KEY_UP, KEY_LEFT, KEY_DOWN));
    // six new presses and six releases in one report
    report_queue.push_back(make_report(KEY_Q, KEY_W, KEY_E,
                                       KEY_LALT, KEY_SPACE, KEY_ESC));
    // two codes sharing the start button
    report_queue.push_back(make_report(KEY_ENTER, KEY_KPENT, KEY_D,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    // releasing one of them clears the shared bit
    report_queue.push_back(make_report(KEY_NONE, KEY_KPENT, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    // repeated code gives one press per slot
    report_queue.push_back(make_report(KEY_RALT, KEY_RALT, KEY_LALT,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    // all ones, unmapped; repeated code releases per slot
    report_queue.push_back(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // unmapped codes only
    report_queue.push_back(make_report(8'h01, 8'h02, 8'h80, 8'h7F, 8'h55, 8'hAA));
    report_queue.push_back(make_report(KEY_NONE, KEY_NONE, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_NONE));
    report_queue.push_back(make_report(KEY_A, KEY_NONE, 8'hFF,
                                       KEY_ESC, KEY_NONE, KEY_SPACE));
    report_queue.push_back(make_report(KEY_NONE, KEY_NONE, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_E));
    report_queue.push_back(make_report(KEY_NONE, KEY_NONE, KEY_NONE,
                                       KEY_NONE, KEY_NONE, KEY_NONE));

    // random requests, mostly small edits of the previous report
    prev_r = report_queue[report_queue.size() - 1];
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      r = prev_r;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        repeat ($urandom_range(1, 2)) begin
          idx = $urandom_range(0, SLOTS - 1);
          r.keys[idx] = pick_key();
        end
      end else if (mode < 70) begin
        for (int i = 0; i < SLOTS; i++) r.keys[i] = prev_r.keys[(i + 1) % SLOTS];
      end else if (mode < 90) begin
        for (int i = 0; i < SLOTS; i++) r.keys[i] = pick_key();
      end else begin
        for (int i = 0; i < SLOTS; i++) r.keys[i] = code_t'($urandom_range(0, 255));
      end
      report_queue.push_back(r);
      prev_r = r;
    end
    total_reports = report_queue.size();

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for all requests and events, then let the pipeline settle
    while (report_queue.size() > 0 || reports_accepted != reports_sent ||
           expected_events.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d reports, %0d events (%0d presses, %0d releases)",
             reports_accepted, events_checked, press_count, release_count);
    $display("%0d reports without events, %0d with twelve events, %0d input stall cycles",
             silent_reports, full_reports, input_stall_cycles);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d events missing", mismatch_count, expected_events.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
